// ----- rtl/core/sfla_pkg.sv -----
// Shared types, constants and helpers for the segregated free-list allocator core.
// No dependencies.
package sfla_pkg;

  localparam int unsigned HeapBytesDef  = 65536;
  localparam int unsigned ClassCountDef = 8;
  localparam logic [31:0] HdrMagic      = 32'hDEADBEEF;
  localparam int unsigned HdrBytes      = 16;

  localparam logic [2:0] StAlloc   = 3'd0;
  localparam logic [2:0] StFreed   = 3'd1;
  localparam logic [2:0] StNoMem   = 3'd2;
  localparam logic [2:0] StZero    = 3'd3;
  localparam logic [2:0] StNull    = 3'd4;
  localparam logic [2:0] StBadMag  = 3'd5;

  typedef struct packed {
    logic [31:0] alloc_cnt;
    logic [31:0] free_cnt;
    logic [31:0] fail_cnt;
    logic [16:0] cur_bytes;
    logic [16:0] peak_bytes;
  } stats_t;

  function automatic logic [31:0] sat_inc(input logic [31:0] x);
    return (x == 32'hFFFF_FFFF) ? x : x + 32'd1;
  endfunction

endpackage

// ----- rtl/core/segregated_free_list_allocator_core.sv -----
// Segregated free-list allocator: one request item in, one result item out.
// Sequencer over one heap RAM port.
// Depends on sfla_pkg and sfla_ram.
//
// Input channel (in_valid_i / in_stall_o) carries req_type, request_size and
// free_address. Output channel (out_valid_o / out_stall_i) carries status,
// payload address and the counters, held in an output register.
// Zero size, null free and bad address are answered from decode; a free checks
// the header magic, reads the size and pushes the block onto its list; a class
// pop reads the link word; a large-list allocation walks the list block by block.
// The heap RAM port moves one 64-bit granule per cycle, with a registered read.
// The block takes one item at a time; the next item can be accepted in the same
// cycle as the result becomes valid, or later while a result is held under a stalled receiver.
// A held result blocks the input until it is taken; it may be taken in the
// same cycle as the next item.
// Reset and a heap size write start a clearing pass over every granule of the
// RAM, then write the initial free block; no item is accepted during it.
// A heap size write is taken while idle or clearing, never with an item in flight.
module segregated_free_list_allocator_core
  import sfla_pkg::*;
#(
  parameter int unsigned HEAP_BYTES  = HeapBytesDef,
  parameter int unsigned CLASS_COUNT = ClassCountDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [16:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [15:0] request_size_i,
  input  logic [15:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [15:0] payload_address_o,
  output logic [31:0] allocation_count_o,
  output logic [31:0] free_count_o,
  output logic [31:0] failure_count_o,
  output logic [16:0] bytes_in_use_o,
  output logic [16:0] peak_bytes_in_use_o
);
  localparam int unsigned GCount = HEAP_BYTES / 8;
  localparam int unsigned GW     = $clog2(GCount);
  localparam int unsigned CW     = (CLASS_COUNT > 1) ? $clog2(CLASS_COUNT) : 1;
  localparam int unsigned HW     = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned NW     = (HW > 17) ? HW : 17;

  localparam logic [4:0] S_CLR   = 5'd0;
  localparam logic [4:0] S_IDLE  = 5'd1;
  localparam logic [4:0] S_DEC   = 5'd2;
  localparam logic [4:0] S_CPOP  = 5'd3;
  localparam logic [4:0] S_CPOPW = 5'd4;
  localparam logic [4:0] S_WRD0  = 5'd5;
  localparam logic [4:0] S_WRD1  = 5'd6;
  localparam logic [4:0] S_WRD1W = 5'd7;
  localparam logic [4:0] S_WCHK  = 5'd8;
  localparam logic [4:0] S_UNLNK = 5'd9;
  localparam logic [4:0] S_REM0  = 5'd10;
  localparam logic [4:0] S_REM1  = 5'd11;
  localparam logic [4:0] S_HDR0  = 5'd12;
  localparam logic [4:0] S_HDR1  = 5'd13;
  localparam logic [4:0] S_FRD1  = 5'd14;
  localparam logic [4:0] S_FRD1W = 5'd15;
  localparam logic [4:0] S_FRD0  = 5'd16;
  localparam logic [4:0] S_FRD0W = 5'd17;
  localparam logic [4:0] S_FPUT0 = 5'd18;
  localparam logic [4:0] S_FPUT1 = 5'd19;
  localparam logic [4:0] S_DONE  = 5'd20;
  localparam logic [4:0] S_INIT0 = 5'd21;
  localparam logic [4:0] S_INIT1 = 5'd22;

  logic [4:0]    st_q, st_d;
  logic [HW-1:0] heap_q, heap_d;
  logic [GW:0]   clr_q, clr_d;
  logic [GW-1:0] chead_q [CLASS_COUNT];
  logic [GW-1:0] chead_d [CLASS_COUNT];
  logic [CLASS_COUNT-1:0] cval_q, cval_d;
  logic [GW-1:0] lhead_q, lhead_d;
  logic          lval_q, lval_d;
  stats_t        stats_q, stats_d;

  logic          rtype_q, rtype_d;
  logic [15:0]   rsize_q, rsize_d;
  logic [15:0]   faddr_q, faddr_d;
  logic [NW-1:0] need_q, need_d;
  logic [CW-1:0] cls_q, cls_d;
  logic          isc_q, isc_d;
  logic [GW-1:0] cur_q, cur_d, prev_q, prev_d, nx_q, nx_d;
  logic          nv_q, nv_d, hprev_q, hprev_d;
  logic [GW:0]   steps_q, steps_d;
  logic [NW-1:0] bsz_q, bsz_d;

  logic          ov_q, ov_d;
  logic [2:0]    ost_q, ost_d;
  logic [15:0]   opay_q, opay_d;
  stats_t        ostat_q, ostat_d;

  logic          we;
  logic [GW-1:0] addr;
  logic [63:0]   wdata, rdata;

  sfla_ram #(.Width(64), .Depth(GCount)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  logic [GW:0]   hg;
  logic [16:0]   total;
  logic [16:0]   cfg_v;
  logic [NW-1:0] rem;
  logic [GW:0]   rg;
  logic [17:0]   cur_sum;
  logic [16:0]   fsz;

  assign hg = heap_q[HW-1:3];

  always_comb begin
    cfg_v = cfg_wdata_i;
    if (cfg_v < 17'd64) cfg_v = 17'd64;
    if ({15'd0, cfg_v} > 32'(HEAP_BYTES)) cfg_v = 17'(HEAP_BYTES);
    cfg_v[2:0] = 3'd0;
  end

  assign total = (17'(rsize_q) + 17'd23) & ~17'd7;
  assign rem   = bsz_q - need_q;
  assign rg    = (GW + 1)'(cur_q) + (GW + 1)'(need_q >> 3);
  assign fsz   = rdata[16:0];

  always_comb begin
    st_d = st_q; heap_d = heap_q; clr_d = clr_q;
    chead_d = chead_q; cval_d = cval_q; lhead_d = lhead_q; lval_d = lval_q;
    stats_d = stats_q;
    rtype_d = rtype_q; rsize_d = rsize_q; faddr_d = faddr_q;
    need_d = need_q; cls_d = cls_q; isc_d = isc_q;
    cur_d = cur_q; prev_d = prev_q; nx_d = nx_q; nv_d = nv_q; hprev_d = hprev_q;
    steps_d = steps_q; bsz_d = bsz_q;
    ov_d = ov_q; ost_d = ost_q; opay_d = opay_q; ostat_d = ostat_q;
    we = 1'b0; addr = '0; wdata = '0; cur_sum = '0;

    if (ov_q && !out_stall_i) ov_d = 1'b0;

    unique case (st_q)
      S_CLR: begin
        we = 1'b1; addr = clr_q[GW-1:0];
        if (clr_q == (GW + 1)'(GCount - 1)) st_d = S_INIT0;
        else clr_d = clr_q + 1'b1;
      end
      S_INIT0: begin
        we = 1'b1; addr = '0; st_d = S_INIT1;
      end
      S_INIT1: begin
        we = 1'b1; addr = GW'(1); wdata = 64'(heap_q); st_d = S_IDLE;
      end
      S_IDLE: begin
        if (cfg_we_i) begin
          heap_d = HW'(cfg_v); clr_d = '0; st_d = S_CLR;
          cval_d = '0; lhead_d = '0; lval_d = 1'b1; stats_d = '0;
        end else if (in_valid_i && !(ov_q && out_stall_i)) begin
          rtype_d = req_type_i; rsize_d = request_size_i; faddr_d = free_address_i;
          st_d = S_DEC;
        end
      end
      S_DEC: begin
        if (!rtype_q) begin
          if (rsize_q == 16'd0) begin
            ost_d = StZero; opay_d = '0; st_d = S_DONE;
          end else begin
            isc_d = 1'b0; need_d = NW'(total); cls_d = '0;
            for (int c = CLASS_COUNT - 1; c >= 0; c--) begin
              if (total <= 17'(32'd16 << c)) begin
                isc_d = 1'b1; cls_d = CW'(c); need_d = NW'(32'd16 << c);
              end
            end
            cur_d = lhead_q; nv_d = lval_q; hprev_d = 1'b0; steps_d = '0;
            if (isc_d && cval_q[cls_d] &&
                (GW + 1)'(chead_q[cls_d]) + 1'b1 < hg) begin
              cur_d = chead_q[cls_d]; st_d = S_CPOP;
            end else st_d = S_WRD0;
          end
        end else begin
          if (faddr_q == 16'd0) begin
            ost_d = StNull; opay_d = '0; st_d = S_DONE;
          end else if (faddr_q < 16'd16 || faddr_q[2:0] != 3'd0 ||
                       32'((faddr_q - 16'd16) >> 3) + 32'd1 >= 32'(hg)) begin
            ost_d = StBadMag; opay_d = '0; st_d = S_DONE;
          end else begin
            cur_d = GW'((faddr_q - 16'd16) >> 3); st_d = S_FRD1;
          end
        end
      end
      S_CPOP: begin
        addr = cur_q; st_d = S_CPOPW;
      end
      S_CPOPW: begin
        chead_d[cls_q] = rdata[GW-1:0]; cval_d[cls_q] = rdata[32];
        st_d = S_HDR0;
      end
      S_WRD0: begin
        if (!nv_q || steps_q >= (GW + 1)'(GCount) ||
            (GW + 1)'(cur_q) + 1'b1 >= hg) begin
          stats_d.fail_cnt = sat_inc(stats_q.fail_cnt);
          ost_d = StNoMem; opay_d = '0; st_d = S_DONE;
        end else begin
          addr = cur_q; st_d = S_WRD1;
        end
      end
      S_WRD1: begin
        addr = cur_q + 1'b1;
        nx_d = rdata[GW-1:0]; nv_d = rdata[32]; st_d = S_WRD1W;
      end
      S_WRD1W: begin
        addr = cur_q + 1'b1; st_d = S_WCHK;
      end
      S_WCHK: begin
        bsz_d = NW'(rdata[31:0]);
        if (rdata[31:0] >= 32'(need_q)) begin
          if (hprev_q) st_d = S_UNLNK;
          else begin
            lhead_d = nx_q; lval_d = nv_q; st_d = S_REM0;
          end
        end else begin
          prev_d = cur_q; hprev_d = 1'b1; cur_d = nx_q; steps_d = steps_q + 1'b1;
          st_d = S_WRD0;
        end
      end
      S_UNLNK: begin
        we = 1'b1; addr = prev_q; wdata = {31'd0, nv_q, 32'(nx_q)};
        st_d = S_REM0;
      end
      S_REM0: begin
        if (rem >= NW'(16) && rg + 1'b1 < hg) begin
          we = 1'b1; addr = rg[GW-1:0]; wdata = {31'd0, lval_q, 32'(lhead_q)};
          st_d = S_REM1;
        end else st_d = S_HDR0;
      end
      S_REM1: begin
        we = 1'b1; addr = rg[GW-1:0] + 1'b1; wdata = 64'(rem);
        lhead_d = rg[GW-1:0]; lval_d = 1'b1; st_d = S_HDR0;
      end
      S_HDR0: begin
        we = 1'b1; addr = cur_q; wdata = 64'(need_q); st_d = S_HDR1;
      end
      S_HDR1: begin
        we = 1'b1; addr = cur_q + 1'b1; wdata = {32'd0, HdrMagic};
        stats_d.alloc_cnt = sat_inc(stats_q.alloc_cnt);
        cur_sum = 18'(stats_q.cur_bytes) + 18'(need_q);
        stats_d.cur_bytes = cur_sum[17] ? 17'h1FFFF : cur_sum[16:0];
        if (stats_d.cur_bytes > stats_q.peak_bytes) stats_d.peak_bytes = stats_d.cur_bytes;
        ost_d = StAlloc; opay_d = 16'({cur_q, 3'd0} + 16);
        st_d = S_DONE;
      end
      S_FRD1: begin
        addr = cur_q + 1'b1; st_d = S_FRD1W;
      end
      S_FRD1W: begin
        if (rdata != {32'd0, HdrMagic}) begin
          ost_d = StBadMag; opay_d = '0; st_d = S_DONE;
        end else st_d = S_FRD0;
      end
      S_FRD0: begin
        addr = cur_q; st_d = S_FRD0W;
      end
      S_FRD0W: begin
        bsz_d = NW'(rdata[31:0]);
        stats_d.free_cnt = sat_inc(stats_q.free_cnt);
        stats_d.cur_bytes = (rdata[31:0] > 32'(stats_q.cur_bytes)) ? 17'd0 :
                            stats_q.cur_bytes - fsz;
        isc_d = 1'b0; cls_d = '0;
        for (int c = 0; c < CLASS_COUNT; c++) begin
          if (rdata[31:0] == (32'd16 << c)) begin
            isc_d = 1'b1; cls_d = CW'(c);
          end
        end
        st_d = S_FPUT0;
      end
      S_FPUT0: begin
        we = 1'b1; addr = cur_q;
        if (isc_q) begin
          wdata = {31'd0, cval_q[cls_q], 32'(chead_q[cls_q])};
          chead_d[cls_q] = cur_q; cval_d[cls_q] = 1'b1;
        end else begin
          wdata = {31'd0, lval_q, 32'(lhead_q)};
          lhead_d = cur_q; lval_d = 1'b1;
        end
        st_d = S_FPUT1;
      end
      S_FPUT1: begin
        we = 1'b1; addr = cur_q + 1'b1; wdata = 64'(bsz_q);
        ost_d = StFreed; opay_d = '0; st_d = S_DONE;
      end
      S_DONE: begin
        if (!ov_d) begin
          ov_d = 1'b1; ostat_d = stats_q; st_d = S_IDLE;
        end
      end
      default: st_d = S_IDLE;
    endcase

    // heap size write during a clearing pass restarts it
    if (cfg_we_i && (st_q inside {S_CLR, S_INIT0, S_INIT1})) begin
      heap_d = HW'(cfg_v); clr_d = '0; st_d = S_CLR;
      cval_d = '0; lhead_d = '0; lval_d = 1'b1; stats_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_CLR; heap_q <= HW'((HEAP_BYTES < 65536 ? HEAP_BYTES : 65536) / 8 * 8);
      clr_q <= '0; cval_q <= '0; lhead_q <= '0; lval_q <= 1'b1;
      stats_q <= '0; ov_q <= 1'b0;
    end else begin
      st_q <= st_d; heap_q <= heap_d; clr_q <= clr_d; cval_q <= cval_d;
      lhead_q <= lhead_d; lval_q <= lval_d; stats_q <= stats_d; ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chead_q <= chead_d;
    rtype_q <= rtype_d; rsize_q <= rsize_d; faddr_q <= faddr_d;
    need_q <= need_d; cls_q <= cls_d; isc_q <= isc_d;
    cur_q <= cur_d; prev_q <= prev_d; nx_q <= nx_d; nv_q <= nv_d; hprev_q <= hprev_d;
    steps_q <= steps_d; bsz_q <= bsz_d;
    ost_q <= ost_d; opay_q <= opay_d; ostat_q <= ostat_d;
  end

  assign in_stall_o          = (st_q != S_IDLE) || cfg_we_i || (ov_q && out_stall_i);
  assign out_valid_o         = ov_q;
  assign status_o            = ost_q;
  assign payload_address_o   = opay_q;
  assign allocation_count_o  = ostat_q.alloc_cnt;
  assign free_count_o        = ostat_q.free_cnt;
  assign failure_count_o     = ostat_q.fail_cnt;
  assign bytes_in_use_o      = ostat_q.cur_bytes;
  assign peak_bytes_in_use_o = ostat_q.peak_bytes;

  a_peak: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stats_q.peak_bytes >= stats_q.cur_bytes || st_q == S_CLR) else $error("peak");
  a_pay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ov_q && ost_q != StAlloc |-> opay_q == 16'd0) else $error("payload");
  a_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == S_DEC) else $error("accept");
endmodule

// ----- rtl/core/sfla_ram.sv -----
// Generic single-port RAM with registered read.
// No dependencies.
module sfla_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 8192
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[addr_i] <= wdata_i;
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ----- dv/segregated_free_list_allocator_core_tb.sv -----
// Testbench for segregated_free_list_allocator_core: directed and random alloc/free items,
// checked against an in-bench heap predictor. Depends on sfla_pkg and the core RTL.
`timescale 1ns / 100ps

module segregated_free_list_allocator_core_tb;
  import sfla_pkg::*;

  localparam int unsigned Granules = HeapBytesDef / 8;
  localparam int unsigned WatchLimit = 20 * Granules + 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] payload;
    logic [31:0] alloc_cnt;
    logic [31:0] free_cnt;
    logic [31:0] fail_cnt;
    logic [16:0] cur_bytes;
    logic [16:0] peak_bytes;
  } heap_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [16:0] cfg_wdata_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = 1'b0;
  logic [15:0] request_size_i = '0;
  logic [15:0] free_address_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [15:0] payload_address_o;
  logic [31:0] allocation_count_o, free_count_o, failure_count_o;
  logic [16:0] bytes_in_use_o, peak_bytes_in_use_o;

  segregated_free_list_allocator_core dut (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // heap model
  logic [31:0] lo_word [Granules];
  logic [31:0] hi_word [Granules];
  logic [31:0] cls_head [ClassCountDef];
  bit          cls_ok [ClassCountDef];
  logic [31:0] big_head;
  bit          big_ok;
  logic [31:0] heap_len;
  logic [31:0] n_alloc, n_free, n_fail, cur_b, peak_b;

  heap_result_t expected_q[$];
  logic [15:0]  live_addr[$];
  int           errors = 0;
  int           seen = 0;
  int           sent = 0;
  int           send_idle = 0;
  int           recv_stall = 0;
  int           idle_cycles = 0;
  bit           stim_done = 1'b0;

  function automatic void store_free(logic [31:0] g, logic [31:0] nx, bit nv,
                                     logic [31:0] sz);
    lo_word[g] = nx; hi_word[g] = nv;
    lo_word[g + 1] = sz; hi_word[g + 1] = 0;
  endfunction

  function automatic void heap_init(logic [31:0] size);
    heap_len = size;
    foreach (lo_word[i]) begin
      lo_word[i] = 0; hi_word[i] = 0;
    end
    foreach (cls_head[i]) begin
      cls_head[i] = 0; cls_ok[i] = 0;
    end
    big_head = 0; big_ok = 1;
    store_free(0, 0, 0, size);
    n_alloc = 0; n_free = 0; n_fail = 0; cur_b = 0; peak_b = 0;
  endfunction

  function automatic int size_class(logic [31:0] s);
    for (int c = 0; c < ClassCountDef; c++)
      if (s <= (32'd16 << c)) return c;
    return -1;
  endfunction

  function automatic bit first_fit(logic [31:0] need, output logic [31:0] blk,
                                   output logic [31:0] bsz);
    logic [31:0] hg, cur, prev, steps, nx, sz;
    bit v, nv, hp;
    hg = heap_len / 8; cur = big_head; prev = 0; steps = 0; v = big_ok; hp = 0;
    blk = 0; bsz = 0;
    while (v && steps < Granules) begin
      if (cur + 1 >= hg) break;
      nx = lo_word[cur]; nv = hi_word[cur][0]; sz = lo_word[cur + 1];
      if (sz >= need) begin
        if (hp) begin
          lo_word[prev] = nx; hi_word[prev] = nv;
        end else begin
          big_head = nx; big_ok = nv;
        end
        blk = cur; bsz = sz;
        return 1;
      end
      prev = cur; hp = 1; cur = nx; v = nv; steps++;
    end
    return 0;
  endfunction

  function automatic void split_block(logic [31:0] blk, logic [31:0] bsz, logic [31:0] used);
    logic [31:0] rem, r;
    rem = bsz - used; r = blk + used / 8;
    if (rem >= 16 && r + 1 < heap_len / 8) begin
      store_free(r, big_head, big_ok, rem);
      big_head = r; big_ok = 1;
    end
  endfunction

  function automatic heap_result_t predict_heap(bit kind, logic [15:0] req,
                                                logic [15:0] addr);
    heap_result_t r;
    logic [31:0] total, blk, bsz, rec, hg, h, sz;
    int c;
    bit got;
    r = '0; hg = heap_len / 8; got = 0; blk = 0; bsz = 0;
    if (!kind) begin
      if (req == 0) begin
        r.status = StZero;
      end else begin
        total = (32'(req) + 23) & ~32'd7;
        rec = total;
        c = size_class(total);
        if (c >= 0) begin
          rec = 32'd16 << c;
          if (cls_ok[c] && cls_head[c] + 1 < hg) begin
            blk = cls_head[c];
            cls_head[c] = lo_word[blk];
            cls_ok[c] = hi_word[blk][0];
            got = 1;
          end else if (first_fit(rec, blk, bsz)) begin
            split_block(blk, bsz, rec); got = 1;
          end
        end else if (first_fit(total, blk, bsz)) begin
          split_block(blk, bsz, total); got = 1;
        end
        if (got) begin
          lo_word[blk] = rec; hi_word[blk] = 0;
          lo_word[blk + 1] = HdrMagic; hi_word[blk + 1] = 0;
          n_alloc = sat_inc(n_alloc);
          cur_b += rec;
          if (cur_b > 32'h1FFFF) cur_b = 32'h1FFFF;
          if (cur_b > peak_b) peak_b = cur_b;
          r.payload = 16'(blk * 8 + 16);
          r.status = StAlloc;
        end else begin
          n_fail = sat_inc(n_fail);
          r.status = StNoMem;
        end
      end
    end else begin
      if (addr == 0) begin
        r.status = StNull;
      end else if (addr < 16 || addr[2:0] != 0 || (32'(addr) - 16) / 8 + 1 >= hg) begin
        r.status = StBadMag;
      end else begin
        h = (32'(addr) - 16) / 8;
        if (lo_word[h + 1] != HdrMagic || hi_word[h + 1] != 0) begin
          r.status = StBadMag;
        end else begin
          sz = lo_word[h];
          n_free = sat_inc(n_free);
          cur_b = (sz > cur_b) ? 0 : cur_b - sz;
          c = size_class(sz);
          if (c >= 0 && sz == (32'd16 << c)) begin
            store_free(h, cls_head[c], cls_ok[c], sz);
            cls_head[c] = h; cls_ok[c] = 1;
          end else begin
            store_free(h, big_head, big_ok, sz);
            big_head = h; big_ok = 1;
          end
          r.status = StFreed;
        end
      end
    end
    r.alloc_cnt = n_alloc; r.free_cnt = n_free; r.fail_cnt = n_fail;
    r.cur_bytes = cur_b[16:0]; r.peak_bytes = peak_b[16:0];
    return r;
  endfunction

  task automatic send_request(bit kind, logic [15:0] req, logic [15:0] addr);
    heap_result_t r;
    while (send_idle > 0 && $urandom_range(99) < send_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    request_size_i <= req;
    free_address_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    r = predict_heap(kind, req, addr);
    expected_q.push_back(r);
    if (r.status == StAlloc) live_addr.push_back(r.payload);
    sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic set_heap(logic [16:0] v);
    logic [31:0] c;
    drain();
    c = (v < 64) ? 64 : v;
    if (c > HeapBytesDef) c = HeapBytesDef;
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    heap_init(c & ~32'd7);
    live_addr.delete();
  endtask

  function automatic logic [15:0] pick_live();
    int i;
    logic [15:0] a;
    if (live_addr.size() == 0) return 16'(($urandom_range(200) * 8) + 16);
    i = $urandom_range(live_addr.size() - 1);
    a = live_addr[i];
    live_addr.delete(i);
    return a;
  endfunction

  task automatic random_items(int n, int max_req);
    int k;
    for (int i = 0; i < n; i++) begin
      k = $urandom_range(99);
      if (k < 50) send_request(0, 16'($urandom_range(max_req, 1)), 16'($urandom));
      else if (k < 85) send_request(1, 16'($urandom), pick_live());
      else if (k < 90) send_request(0, 16'($urandom), 16'($urandom));
      else if (k < 93) send_request(0, 16'd0, 16'($urandom));
      else if (k < 96) send_request(1, 16'($urandom), 16'd0);
      else send_request(1, 16'($urandom), 16'($urandom));
    end
  endtask

  task automatic test_directed();
    send_request(0, 16'd0, 16'hFFFF);
    send_request(1, 16'hFFFF, 16'd0);
    send_request(0, 16'd1, 16'd0);
    for (int c = 0; c < 8; c++) send_request(0, 16'((16 << c) - 16), 16'd0);
    send_request(0, 16'd3000, 16'd0);
    send_request(1, 16'd0, 16'd16);
    send_request(1, 16'd0, 16'd16);
    send_request(1, 16'd0, 16'd8);
    send_request(1, 16'd0, 16'd21);
    send_request(1, 16'd0, 16'hFFF8);
    send_request(0, 16'd1, 16'd0);
    send_request(0, 16'hFFFF, 16'd0);
    send_request(0, 16'd60000, 16'd0);
    send_request(1, 16'd0, pick_live());
    send_request(0, 16'd5000, 16'd0);
  endtask

  task automatic test_small_heap();
    set_heap(17'd0);
    send_request(0, 16'd8, 16'd0);
    send_request(0, 16'd8, 16'd0);
    send_request(0, 16'd40, 16'd0);
    random_items(60, 60);
    set_heap(17'd100);
    random_items(80, 90);
    set_heap(17'h1FFFF);
  endtask

  task automatic test_random_phases();
    int idle_s[4] = '{0, 55, 0, 18};
    int idle_r[4] = '{0, 0, 55, 18};
    for (int p = 0; p < 4; p++) begin
      send_idle = idle_s[p];
      recv_stall = idle_r[p];
      random_items(200, 3000);
      random_items(100, 300);
      random_items(50, 65535);
    end
    set_heap(17'd4096);
    send_idle = 18; recv_stall = 18;
    random_items(200, 600);
    set_heap(17'd65536);
    random_items(150, 2000);
  endtask

  always @(posedge clk_i) begin
    if (stim_done) out_stall_i <= 1'b0;
    else out_stall_i <= ($urandom_range(99) < recv_stall);
  end

  always @(posedge clk_i) begin
    heap_result_t e;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen++;
      if (expected_q.size() == 0) begin
        $error("unexpected result item, status %0d", status_o);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (status_o !== e.status) begin
          $error("status exp %0d got %0d", e.status, status_o); errors++;
        end
        if (payload_address_o !== e.payload) begin
          $error("payload_address exp %0h got %0h", e.payload, payload_address_o); errors++;
        end
        if (allocation_count_o !== e.alloc_cnt) begin
          $error("allocation_count exp %0d got %0d", e.alloc_cnt, allocation_count_o);
          errors++;
        end
        if (free_count_o !== e.free_cnt) begin
          $error("free_count exp %0d got %0d", e.free_cnt, free_count_o); errors++;
        end
        if (failure_count_o !== e.fail_cnt) begin
          $error("failure_count exp %0d got %0d", e.fail_cnt, failure_count_o); errors++;
        end
        if (bytes_in_use_o !== e.cur_bytes) begin
          $error("bytes_in_use exp %0d got %0d", e.cur_bytes, bytes_in_use_o); errors++;
        end
        if (peak_bytes_in_use_o !== e.peak_bytes) begin
          $error("peak_bytes_in_use exp %0d got %0d", e.peak_bytes, peak_bytes_in_use_o);
          errors++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      $display("watchdog: no item moved in %0d cycles", idle_cycles);
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    heap_init(HeapBytesDef);
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_small_heap();
    test_random_phases();
    stim_done = 1'b1;
    drain();
    if (expected_q.size() != 0) begin
      $error("%0d results never arrived", expected_q.size());
      errors++;
    end
    $display("sent %0d items, checked %0d results over heap sizes 64..65536", sent, seen);
    $display("with sender gaps and receiver stalls; %0d mismatches", errors);
    if (errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

// ----- segregated_free_list_allocator_core.f -----
rtl/core/sfla_pkg.sv
rtl/core/sfla_ram.sv
rtl/core/segregated_free_list_allocator_core.sv
dv/segregated_free_list_allocator_core_tb.sv
